FILE: rtl/core/z80ld_pkg.sv
// shared types, opcodes and controller states for the 16-bit load executor
package z80ld_pkg;

    localparam int ADDR_BITS_DEF = 16;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_EXEC  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam logic [7:0] OP_LD_NN_MASK = 8'b00110000;
    localparam logic [7:0] OP_PFX_ED     = 8'b11101101;
    localparam logic [7:0] OP_PFX_DD     = 8'b11011101;
    localparam logic [7:0] OP_PFX_FD     = 8'b11111101;
    localparam logic [7:0] OP_LD_SP_HL   = 8'b11111001;
    localparam logic [7:0] OP_LD_HL_MEM  = 8'b00101010;
    localparam logic [7:0] OP_LD_MEM_HL  = 8'b00100010;
    localparam logic [7:0] OP_LD_HL_NN   = 8'b00100001;
    localparam logic [7:0] OP_PUSH_HL    = 8'b11100101;
    localparam logic [7:0] OP_POP_HL     = 8'b11100001;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] mem_addr;
        logic [7:0]  mem_data;
    } t_in_beat;

    typedef struct packed {
        logic [4:0]  t_states;
        logic [7:0]  mem_byte;
        logic [15:0] pc_value;
        logic [15:0] sp_value;
        logic [15:0] af_value;
        logic [15:0] bc_value;
        logic [15:0] de_value;
        logic [15:0] hl_value;
        logic [15:0] ix_value;
        logic [15:0] iy_value;
    } t_out_beat;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLEAR, ST_HOST, ST_F0, ST_F1, ST_F2, ST_F3,
        ST_DEC, ST_D0, ST_D1, ST_DONE, ST_OUT
    } t_state;

    // register selection codes
    typedef enum logic [2:0] {
        RS_BC, RS_DE, RS_HL, RS_SP, RS_AF, RS_IX, RS_IY
    } t_rsel;

    typedef enum logic [2:0] {
        K_NONE, K_IMM, K_LOAD, K_STORE, K_SPLD, K_PUSH, K_POP
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        t_rsel       rsel;
        logic        imm23;   // operand in bytes 2..3
        logic [2:0]  len;
        logic [4:0]  tst;
    } t_decode;

    // commands from controller to datapath
    typedef struct packed {
        logic        mem_en;
        logic        mem_we;
        logic [1:0]  asel;     // 0 host, 1 pc+k, 2 operand+k, 3 stack
        logic [1:0]  aoff;
        logic [1:0]  lidx;      // slot for the fetched opcode byte
        logic        wsel_hi;   // high byte: of value on stores, into r_hi on data capture
        logic        wsel_host;
        logic        lat_fetch; // capture fetched byte at slot lidx
        logic        lat_data;  // capture data byte
        logic        commit;
        logic        sp_dec;
        logic        sp_inc;
        logic        clr;
    } t_cmd;

    typedef struct packed {
        t_decode dec;
        logic    clr_last;
    } t_status;

    function automatic t_decode decode(input logic [7:0] b0, input logic [7:0] b1);
        t_decode d;
        d = '{kind: K_NONE, rsel: RS_BC, imm23: 1'b0, len: 3'd0, tst: 5'd0};
        if ((b0 & ~OP_LD_NN_MASK) == 8'h01) begin
            d = '{K_IMM, t_rsel'({1'b0, b0[5:4]}), 1'b0, 3'd3, 5'd10};
        end else if (b0 == OP_LD_HL_MEM) begin
            d = '{K_LOAD, RS_HL, 1'b0, 3'd3, 5'd16};
        end else if (b0 == OP_LD_MEM_HL) begin
            d = '{K_STORE, RS_HL, 1'b0, 3'd3, 5'd16};
        end else if (b0 == OP_LD_SP_HL) begin
            d = '{K_SPLD, RS_HL, 1'b0, 3'd1, 5'd6};
        end else if ((b0 & ~OP_LD_NN_MASK) == 8'hC5) begin
            d = '{K_PUSH, (b0[5:4] == 2'd3) ? RS_AF : t_rsel'({1'b0, b0[5:4]}),
                  1'b0, 3'd1, 5'd11};
        end else if ((b0 & ~OP_LD_NN_MASK) == 8'hC1) begin
            d = '{K_POP, (b0[5:4] == 2'd3) ? RS_AF : t_rsel'({1'b0, b0[5:4]}),
                  1'b0, 3'd1, 5'd10};
        end else if (b0 == OP_PFX_ED) begin
            if ((b1 & 8'hCF) == 8'h4B)
                d = '{K_LOAD, t_rsel'({1'b0, b1[5:4]}), 1'b1, 3'd4, 5'd20};
            else if ((b1 & 8'hCF) == 8'h43)
                d = '{K_STORE, t_rsel'({1'b0, b1[5:4]}), 1'b1, 3'd4, 5'd20};
        end else if (b0 == OP_PFX_DD || b0 == OP_PFX_FD) begin
            d.rsel = (b0 == OP_PFX_DD) ? RS_IX : RS_IY;
            d.imm23 = 1'b1;
            unique case (b1)
                OP_LD_HL_NN:  begin d.kind = K_IMM;   d.len = 3'd4; d.tst = 5'd14; end
                OP_LD_HL_MEM: begin d.kind = K_LOAD;  d.len = 3'd4; d.tst = 5'd20; end
                OP_LD_MEM_HL: begin d.kind = K_STORE; d.len = 3'd4; d.tst = 5'd20; end
                OP_LD_SP_HL:  begin d.kind = K_SPLD;  d.len = 3'd2; d.tst = 5'd10; end
                OP_PUSH_HL:   begin d.kind = K_PUSH;  d.len = 3'd2; d.tst = 5'd15; end
                OP_POP_HL:    begin d.kind = K_POP;   d.len = 3'd2; d.tst = 5'd14; end
                default:      d.kind = K_NONE;
            endcase
        end
        return d;
    endfunction

endpackage

FILE: rtl/core/z80ld_datapath.sv
// register file, byte memory and operand latches
module z80ld_datapath import z80ld_pkg::*; #(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_beat  i_beat,
    input  t_cmd      i_cmd,
    output t_status   o_status,
    output t_out_beat o_res,
    output logic [7:0] o_rdata
);
    localparam int DEPTH = 1 << ADDR_BITS;

    logic [7:0]  r_mem [DEPTH];
    logic [7:0]  r_rdata;
    logic [15:0] r_pc, r_sp, r_af, r_bc, r_de, r_hl, r_ix, r_iy;
    logic [7:0]  r_b [4];
    logic [7:0]  r_lo, r_hi;
    logic [15:0] n_addr;
    logic [15:0] v_src;
    logic [15:0] operand;
    logic [7:0]  wbyte;
    t_decode     dec;
    logic [ADDR_BITS-1:0] r_clr;

    assign dec = decode(r_b[0], r_b[1]);
    assign operand = dec.imm23 ? {r_b[3], r_b[2]} : {r_b[2], r_b[1]};

    always_comb begin
        unique case (dec.rsel)
            RS_BC: v_src = r_bc;
            RS_DE: v_src = r_de;
            RS_HL: v_src = r_hl;
            RS_SP: v_src = r_sp;
            RS_AF: v_src = r_af;
            RS_IX: v_src = r_ix;
            RS_IY: v_src = r_iy;
            default: v_src = r_bc;
        endcase
    end

    always_comb begin
        case (i_cmd.asel)
            2'd0: n_addr = i_beat.mem_addr;
            2'd1: n_addr = r_pc + {14'd0, i_cmd.aoff};
            2'd2: n_addr = operand + {14'd0, i_cmd.aoff};
            default: n_addr = i_cmd.sp_dec ? r_sp - 16'd1 : r_sp;
        endcase
        if (i_cmd.wsel_host) wbyte = i_beat.mem_data;
        else if (i_cmd.wsel_hi) wbyte = v_src[15:8];
        else wbyte = v_src[7:0];
        if (i_cmd.clr) n_addr = 16'(r_clr);
    end

    // single memory port; the clear pass writes zero at the swept address
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_en) begin
            if (i_cmd.mem_we)
                r_mem[n_addr[ADDR_BITS-1:0]] <= i_cmd.clr ? 8'd0 : wbyte;
            r_rdata <= r_mem[n_addr[ADDR_BITS-1:0]];
        end
    end
    assign o_rdata = r_rdata;

    // sweep counter for the post-reset clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr <= '0;
        else if (i_cmd.clr) r_clr <= r_clr + 1'b1;
    end
    assign o_status.clr_last = &r_clr;
    assign o_status.dec = dec;

    logic [15:0] n_val;
    assign n_val = (dec.kind == K_IMM) ? operand : {r_hi, r_lo};

    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_fetch) r_b[i_cmd.lidx] <= r_rdata;
        if (i_cmd.lat_data) begin
            if (i_cmd.wsel_hi) r_hi <= r_rdata;
            else r_lo <= r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0; r_sp <= '0; r_af <= '0; r_bc <= '0;
            r_de <= '0; r_hl <= '0; r_ix <= '0; r_iy <= '0;
        end else begin
            if (i_cmd.sp_dec) r_sp <= r_sp - 16'd1;
            if (i_cmd.sp_inc) r_sp <= r_sp + 16'd1;
            if (i_cmd.commit && dec.kind != K_NONE) begin
                r_pc <= r_pc + {13'd0, dec.len};
                if (dec.kind == K_SPLD) r_sp <= v_src;
                if (dec.kind == K_IMM || dec.kind == K_LOAD || dec.kind == K_POP) begin
                    unique case (dec.rsel)
                        RS_BC: r_bc <= n_val;
                        RS_DE: r_de <= n_val;
                        RS_HL: r_hl <= n_val;
                        RS_SP: r_sp <= n_val;
                        RS_AF: r_af <= n_val;
                        RS_IX: r_ix <= n_val;
                        RS_IY: r_iy <= n_val;
                        default: r_bc <= n_val;
                    endcase
                end
            end
        end
    end

    assign o_res = '{t_states: 5'd0, mem_byte: 8'd0, pc_value: r_pc, sp_value: r_sp,
                     af_value: r_af, bc_value: r_bc, de_value: r_de, hl_value: r_hl,
                     ix_value: r_ix, iy_value: r_iy};
endmodule

FILE: rtl/core/z80ld_ctrl.sv
// controller sequencing the memory clear, host access, fetch, data access and result hand-off
module z80ld_ctrl import z80ld_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_beat i_beat,
    input  t_status  i_status,
    output t_cmd     o_cmd,
    output logic     o_capture,
    output logic     o_read_cmd,
    output logic     o_exec
);
    t_state r_state, n_state;
    logic [1:0] r_cmd, n_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cmd <= CMD_WRITE;
        end else begin
            r_state <= n_state;
            r_cmd <= n_cmd;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cmd = r_cmd;
        o_cmd = '0;
        o_ready = 1'b0;
        o_capture = 1'b0;
        o_read_cmd = (r_cmd == CMD_READ);
        o_exec = (r_cmd == CMD_EXEC);
        o_cmd.asel = 2'd1;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1; o_cmd.mem_en = 1'b1; o_cmd.mem_we = 1'b1;
                if (i_status.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                o_cmd.asel = 2'd0;
                if (i_valid) begin
                    n_cmd = i_beat.cmd;
                    if (i_beat.cmd == CMD_EXEC) begin
                        o_cmd.mem_en = 1'b1; o_cmd.asel = 2'd1; o_cmd.aoff = 2'd0;
                        n_state = ST_F0;
                    end else begin
                        o_cmd.mem_en = (i_beat.cmd != CMD_NONE);
                        o_cmd.mem_we = (i_beat.cmd == CMD_WRITE);
                        o_cmd.wsel_host = 1'b1;
                        n_state = ST_HOST;
                    end
                end
            end
            ST_HOST: n_state = ST_DONE;
            ST_F0: begin
                o_cmd.lat_fetch = 1'b1; o_cmd.lidx = 2'd0;
                n_state = ST_F1;
                o_cmd.mem_en = 1'b1; o_cmd.aoff = 2'd1;
            end
            ST_F1: begin
                o_cmd.lat_fetch = 1'b1; o_cmd.lidx = 2'd1;
                o_cmd.mem_en = 1'b1; o_cmd.aoff = 2'd2;
                n_state = ST_F2;
            end
            ST_F2: begin
                o_cmd.lat_fetch = 1'b1; o_cmd.lidx = 2'd2;
                o_cmd.mem_en = 1'b1; o_cmd.aoff = 2'd3;
                n_state = ST_F3;
            end
            ST_F3: begin
                o_cmd.lat_fetch = 1'b1; o_cmd.lidx = 2'd3;
                n_state = ST_DEC;
            end
            ST_DEC: begin
                // first data access: low byte (loads, stores, pop) or high (push)
                unique case (i_status.dec.kind)
                    K_LOAD: begin
                        o_cmd.mem_en = 1'b1; o_cmd.asel = 2'd2; o_cmd.aoff = 2'd0;
                        n_state = ST_D0;
                    end
                    K_STORE: begin
                        o_cmd.mem_en = 1'b1; o_cmd.mem_we = 1'b1; o_cmd.asel = 2'd2;
                        n_state = ST_D0;
                    end
                    K_PUSH: begin
                        o_cmd.mem_en = 1'b1; o_cmd.mem_we = 1'b1; o_cmd.asel = 2'd3;
                        o_cmd.sp_dec = 1'b1; o_cmd.wsel_hi = 1'b1;
                        n_state = ST_D0;
                    end
                    K_POP: begin
                        o_cmd.mem_en = 1'b1; o_cmd.asel = 2'd3; o_cmd.sp_inc = 1'b1;
                        n_state = ST_D0;
                    end
                    default: begin
                        o_cmd.commit = 1'b1;
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_D0: begin
                unique case (i_status.dec.kind)
                    K_LOAD: begin
                        o_cmd.lat_data = 1'b1;
                        o_cmd.mem_en = 1'b1; o_cmd.asel = 2'd2; o_cmd.aoff = 2'd1;
                    end
                    K_STORE: begin
                        o_cmd.mem_en = 1'b1; o_cmd.mem_we = 1'b1; o_cmd.asel = 2'd2;
                        o_cmd.aoff = 2'd1; o_cmd.wsel_hi = 1'b1;
                    end
                    K_PUSH: begin
                        o_cmd.mem_en = 1'b1; o_cmd.mem_we = 1'b1; o_cmd.asel = 2'd3;
                        o_cmd.sp_dec = 1'b1;
                    end
                    default: begin
                        o_cmd.lat_data = 1'b1;
                        o_cmd.mem_en = 1'b1; o_cmd.asel = 2'd3; o_cmd.sp_inc = 1'b1;
                    end
                endcase
                n_state = ST_D1;
            end
            ST_D1: begin
                if (i_status.dec.kind == K_LOAD || i_status.dec.kind == K_POP) begin
                    o_cmd.lat_data = 1'b1; o_cmd.wsel_hi = 1'b1;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // memory forms update pc (and, for loads and pops, the target register) once data access is over
                if (r_cmd == CMD_EXEC &&
                    (i_status.dec.kind inside {K_LOAD, K_POP, K_STORE, K_PUSH}))
                    o_cmd.commit = 1'b1;
                o_capture = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

FILE: rtl/core/z80_sixteen_bit_load_execute_top.sv
// top level of the z80 16-bit load group executor
// items are taken one at a time; execute is bound by four opcode fetches and up to
// two data accesses on the single-port byte memory
// reset: registers clear to zero, then a clearing pass over all 2^ADDR_BITS
// addresses zeroes memory while ready stays low
module z80_sixteen_bit_load_execute_top import z80ld_pkg::*; #(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_beat o_data
);
    t_cmd       cmd;
    t_status    status;
    t_out_beat  res;
    t_out_beat  n_out;
    logic [7:0] rdata;
    logic       capture, read_cmd, exec, ctrl_ready;
    t_in_beat   r_beat;
    t_out_beat  r_out;
    logic       r_valid;

    // hold the accepted beat for the whole command
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) r_beat <= i_data;
    end

    // result register; input is held off while a result beat waits
    assign o_ready = ctrl_ready && !r_valid;

    z80ld_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid(i_valid && !r_valid), .o_ready(ctrl_ready),
        .i_beat(o_ready ? i_data : r_beat), .i_status(status), .o_cmd(cmd),
        .o_capture(capture), .o_read_cmd(read_cmd), .o_exec(exec)
    );

    z80ld_datapath #(.ADDR_BITS(ADDR_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_beat(o_ready ? i_data : r_beat), .i_cmd(cmd),
        .o_status(status), .o_res(res), .o_rdata(rdata)
    );

    // output register loads in the cycle after the capture strobe, once committed values are settled
    logic r_cap_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cap_d <= 1'b0;
        end else begin
            r_cap_d <= capture;
            if (r_cap_d) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
        end
    end

    logic [7:0] r_mb;

    // register values with the read byte and t-states merged in
    always_comb begin
        n_out = res;
        n_out.mem_byte = r_mb;
        n_out.t_states = exec ? status.dec.tst : 5'd0;
    end

    always_ff @(posedge i_clk) begin
        if (capture) r_mb <= read_cmd ? rdata : 8'd0;
        if (r_cap_d) r_out <= n_out;
    end

    assign o_valid = r_valid;
    assign o_data = r_out;
endmodule
